FILE: rtl/core/fdf_pkg.sv
// shared types, codes and character constants of the fixed-point decimal formatter
// no dependencies; imported by every module of the block

package fdf_pkg;

  localparam int NUM_DIGITS = 5;
  localparam int NUM_CHARS  = 6;
  localparam int VALUE_W    = 16;
  localparam int STEP_BITS  = 2;
  localparam int CONV_STEPS = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(CONV_STEPS);
  localparam int CNT_W      = $clog2(NUM_CHARS + 1);

  typedef logic [3:0] digit_t;
  typedef logic [7:0] char_t;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_STAR  = 8'h2A;

  typedef enum logic [2:0] {
    OP_FIX1  = 3'd0,
    OP_FIX2  = 3'd1,
    OP_FIX3  = 3'd2,
    OP_SFIX2 = 3'd3,
    OP_UDEC  = 3'd4,
    OP_SDEC  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_HAND
  } conv_state_t;

  typedef struct packed {
    op_t                         op;
    logic                        neg;
    digit_t [NUM_DIGITS-1:0]     digits;
  } fmt_req_t;

  // add-3 correction of one bcd digit before it doubles
  function automatic digit_t bcd_adjust(input digit_t d);
    bcd_adjust = (d >= 4'd5) ? digit_t'(d + 4'd3) : d;
  endfunction

endpackage

FILE: rtl/core/fdf_digit_cell.sv
// one bcd digit cell of the double-dabble chain, two bits shifted in per cycle while shift_en is high
// depends on fdf_pkg

module fdf_digit_cell (
  input  logic            clk,
  input  logic            clear,
  input  logic            shift_en,
  input  logic            bit_hi_in,
  input  logic            bit_lo_in,
  output logic            bit_hi_out,
  output logic            bit_lo_out,
  output fdf_pkg::digit_t digit
);
  import fdf_pkg::*;

  digit_t digit_r, digit_nxt;
  digit_t adj_a, mid, adj_b;

  always_comb begin
    adj_a      = bcd_adjust(digit_r);
    mid        = {adj_a[2:0], bit_hi_in};
    adj_b      = bcd_adjust(mid);
    bit_hi_out = adj_a[3];
    bit_lo_out = adj_b[3];
    digit_nxt  = {adj_b[2:0], bit_lo_in};
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      digit_r <= '0;
    end else if (shift_en) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

FILE: rtl/core/fdf_char_emitter.sv
// builds the character string of one converted number and streams it out
// depends on fdf_pkg

module fdf_char_emitter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  fdf_pkg::fmt_req_t req,
  output logic              ready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // char_code[7:0]
  output logic              out_tlast   // last_char
);
  import fdf_pkg::*;

  char_t              chars_r [NUM_CHARS];
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               busy_r, busy_nxt;

  char_t              fix_chars  [NUM_CHARS];
  char_t              sfix_chars [NUM_CHARS];
  char_t              dec_chars  [NUM_CHARS];
  char_t              fmt_chars  [NUM_CHARS];
  logic [CNT_W-1:0]   fmt_cnt;
  logic [CNT_W-1:0]   dec_cnt;
  logic [NUM_DIGITS-1:0] lz;
  int                 k;
  int                 top;
  int                 off;

  // leading-zero flags: lz[i] when all digits from the top down to i are zero
  always_comb begin
    lz[NUM_DIGITS-1] = (req.digits[NUM_DIGITS-1] == 4'd0);
    for (int i = NUM_DIGITS - 2; i >= 0; i--) begin
      lz[i] = lz[i+1] && (req.digits[i] == 4'd0);
    end
  end

  // fixed-point string, k decimals
  always_comb begin
    case (req.op)
      OP_FIX1:  k = 1;
      OP_FIX3:  k = 3;
      default:  k = 2;
    endcase
    for (int p = 0; p < NUM_CHARS; p++) begin
      if (p < 5 - k) begin
        if (lz[4-p] && (4 - p > k)) begin
          fix_chars[p] = CH_SPACE;
        end else begin
          fix_chars[p] = {4'h3, req.digits[4-p]};
        end
      end else if (p == 5 - k) begin
        fix_chars[p] = CH_DOT;
      end else begin
        fix_chars[p] = {4'h3, req.digits[5-p]};
      end
    end
  end

  // signed fix2: minus in the space just before the first shown digit, or overflow
  always_comb begin
    if (req.digits[NUM_DIGITS-1] != 4'd0) begin
      sfix_chars[0] = req.neg ? CH_MINUS : CH_SPACE;
      sfix_chars[1] = CH_STAR;
      sfix_chars[2] = CH_STAR;
      sfix_chars[3] = CH_DOT;
      sfix_chars[4] = CH_STAR;
      sfix_chars[5] = CH_STAR;
    end else begin
      for (int p = 0; p < NUM_CHARS - 1; p++) begin
        if (req.neg && fix_chars[p] == CH_SPACE && fix_chars[p+1] != CH_SPACE) begin
          sfix_chars[p] = CH_MINUS;
        end else begin
          sfix_chars[p] = fix_chars[p];
        end
      end
      sfix_chars[NUM_CHARS-1] = fix_chars[NUM_CHARS-1];
    end
  end

  // plain decimal, optional minus, no leading zeros
  always_comb begin
    top = 0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (req.digits[i] != 4'd0) top = i;
    end
    off = (req.op == OP_SDEC && req.neg) ? 1 : 0;
    for (int p = 0; p < NUM_CHARS; p++) begin
      if (off == 1 && p == 0) begin
        dec_chars[p] = CH_MINUS;
      end else if (top - (p - off) >= 0) begin
        dec_chars[p] = {4'h3, req.digits[3'(top - (p - off))]};
      end else begin
        dec_chars[p] = CH_SPACE;
      end
    end
    dec_cnt = CNT_W'(top + 1 + off);
  end

  always_comb begin
    case (req.op)
      OP_FIX1, OP_FIX2, OP_FIX3: begin
        fmt_chars = fix_chars;
        fmt_cnt   = CNT_W'(NUM_CHARS);
      end
      OP_SFIX2: begin
        fmt_chars = sfix_chars;
        fmt_cnt   = CNT_W'(NUM_CHARS);
      end
      default: begin
        fmt_chars = dec_chars;
        fmt_cnt   = dec_cnt;
      end
    endcase
  end

  assign ready      = !busy_r;
  assign out_tvalid = busy_r;
  assign out_tdata  = chars_r[idx_r];
  assign out_tlast  = (idx_r == cnt_r - CNT_W'(1));

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load && !busy_r) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r && out_tready) begin
      if (out_tlast) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !busy_r) begin
      chars_r <= fmt_chars;
      cnt_r   <= fmt_cnt;
    end
  end

endmodule

FILE: rtl/core/fixed_point_decimal_formatter_unit.sv
// an accepted item passes through 8 conversion steps of the bcd cell chain at 2 bits each,
// then the handoff state, which waits for the emitter to be ready, builds the string and
// loads it; characters then stream out one a cycle while out_tready is high
// a new item is taken only in the idle state, once the last one has been handed off; the
// 8-step double-dabble chain and the handoff set the item rate, and character output
// overlaps the next conversion
// reset: synchronous active-low rst_n clears the control state and the output queue
// depends on fdf_pkg, fdf_digit_cell, fdf_char_emitter

module fixed_point_decimal_formatter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // value[15:0], operation[18:16], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // char_code[7:0]
  output logic        out_tlast   // last_char
);
  import fdf_pkg::*;

  conv_state_t            state_r, state_nxt;
  logic [VALUE_W-1:0]     bin_r;
  logic [STEP_CNT_W-1:0]  step_r;
  op_t                    op_r;
  logic                   neg_r;

  logic [VALUE_W-1:0]     in_value;
  op_t                    in_op;
  logic                   in_acc;
  logic                   op_ok;
  logic                   in_neg;
  logic                   load_item;
  logic                   shift_en;
  logic                   emit_load;
  logic                   emit_ready;
  fmt_req_t               req;

  logic [NUM_DIGITS-1:0]  carry_hi;
  logic [NUM_DIGITS-1:0]  carry_lo;
  digit_t [NUM_DIGITS-1:0] digits;

  assign in_value = in_tdata[VALUE_W-1:0];
  assign in_op    = op_t'(in_tdata[VALUE_W+2:VALUE_W]);
  assign in_acc   = in_tvalid && in_tready;

  always_comb begin
    case (in_op)
      OP_FIX1, OP_FIX2, OP_FIX3, OP_SFIX2, OP_UDEC, OP_SDEC: op_ok = 1'b1;
      default:                                               op_ok = 1'b0;
    endcase
  end

  assign in_neg    = in_value[VALUE_W-1] && (in_op == OP_SFIX2 || in_op == OP_SDEC);
  assign load_item = in_acc && op_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (load_item) state_nxt = ST_CONV;
      ST_CONV: if (step_r == STEP_CNT_W'(CONV_STEPS - 1)) state_nxt = ST_HAND;
      ST_HAND: if (emit_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_tready = 1'b0;
    shift_en  = 1'b0;
    emit_load = 1'b0;
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_CONV: shift_en  = 1'b1;
      ST_HAND: emit_load = 1'b1;
      default: in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_item) begin
        step_r <= '0;
      end else if (shift_en) begin
        step_r <= step_r + STEP_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      bin_r <= in_neg ? VALUE_W'(~in_value + VALUE_W'(1)) : in_value;
      op_r  <= in_op;
      neg_r <= in_neg;
    end else if (shift_en) begin
      bin_r <= {bin_r[VALUE_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
    end
  end

  // bcd cell chain, least significant digit takes the binary msbs
  assign carry_hi[0] = bin_r[VALUE_W-1];
  assign carry_lo[0] = bin_r[VALUE_W-2];

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    if (g < NUM_DIGITS - 1) begin : g_mid
      fdf_digit_cell u_cell (
        .clk        (clk),
        .clear      (load_item),
        .shift_en   (shift_en),
        .bit_hi_in  (carry_hi[g]),
        .bit_lo_in  (carry_lo[g]),
        .bit_hi_out (carry_hi[g+1]),
        .bit_lo_out (carry_lo[g+1]),
        .digit      (digits[g])
      );
    end else begin : g_top
      fdf_digit_cell u_cell (
        .clk        (clk),
        .clear      (load_item),
        .shift_en   (shift_en),
        .bit_hi_in  (carry_hi[g]),
        .bit_lo_in  (carry_lo[g]),
        .bit_hi_out (),
        .bit_lo_out (),
        .digit      (digits[g])
      );
    end
  end

  always_comb begin
    req.op     = op_r;
    req.neg    = neg_r;
    req.digits = digits;
  end

  fdf_char_emitter u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit_load),
    .req        (req),
    .ready      (emit_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
